[rtl/kuz_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kuz_pkg: shared types, tables and GF(2^8) helpers for the block cipher
// S-box, inverse S-box, l-vector and the 32 key schedule constants.
// ----------------------------------------------------------------------------
package kuz_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   sbox_tab_t [256];
  typedef blk_t         const_tab_t [32];

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned NUM_RKEYS = 10;
  localparam int unsigned RK_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] KEY_WORD0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD3 = 8'd3;

  localparam logic [7:0] GF_POLY = 8'hC3;

  localparam sbox_tab_t SBOX = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
    8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
    8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
    8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
    8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
    8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
    8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
    8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
    8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
    8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
    8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
    8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
    8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
    8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
    8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
    8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
    8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  localparam logic [7:0] LCOEF [16] = '{
    8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,8'd251,
    8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148,8'd1
  };

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] a;
    logic [7:0] p;
    a = x;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    end
    return p;
  endfunction

  // byte 0 sits in bits 127:120
  function automatic logic [7:0] lin_sum(input blk_t b);
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < 16; i++) s = s ^ gf_mul(LCOEF[i], b[127-8*i -: 8]);
    return s;
  endfunction

  function automatic blk_t r_fwd(input blk_t b);
    return {lin_sum(b), b[127:8]};
  endfunction

  function automatic blk_t r_inv(input blk_t b);
    blk_t v;
    v = {b[119:0], b[127:120]};
    return {b[119:0], lin_sum(v)};
  endfunction

  function automatic sbox_tab_t gen_sbox_inv();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) t[SBOX[i]] = 8'(i);
    return t;
  endfunction

  localparam sbox_tab_t SBOX_INV = gen_sbox_inv();

  function automatic blk_t s_fwd(input blk_t b);
    blk_t r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = SBOX[b[8*i +: 8]];
    return r;
  endfunction

  function automatic blk_t s_inv(input blk_t b);
    blk_t r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = SBOX_INV[b[8*i +: 8]];
    return r;
  endfunction

  // key schedule constants C(j) = L(j), j = 1..32
  function automatic const_tab_t gen_consts();
    const_tab_t t;
    blk_t c;
    for (int j = 0; j < 32; j++) begin
      c = 128'(j + 1);
      for (int r = 0; r < 16; r++) c = r_fwd(c);
      t[j] = c;
    end
    return t;
  endfunction

  localparam const_tab_t KS_CONST = gen_consts();

endpackage
`default_nettype wire

[rtl/kuznyechik_block_cipher.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kuznyechik_block_cipher: 128-bit block cipher with 256-bit key
// One shared round unit (key XOR, S-box, one R step of L per cycle) under
// a sequencer; the same unit also runs the Feistel key schedule.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, in_func, in_block_*   | in
//  result   | out_valid, out_stall, out_result_*        | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Encrypt runs 9 rounds (key XOR and S, then 16 R steps) and a final key
// XOR; decrypt runs 9 rounds (key XOR, 16 inverse R steps, inverse S) and the final XOR.
// The first block after reset or a key write is preceded by the key schedule
// (32 Feistel steps). Reset clears control and the key words; round keys are
// rebuilt before use. A finished result waits in the output register while
// the next block is taken; a result stalled there holds the sequencer.
// ----------------------------------------------------------------------------
module kuznyechik_block_cipher (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic [63:0]                    in_block_hi,
  input  wire logic [63:0]                    in_block_lo,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [63:0]                         out_result_hi,
  output logic [63:0]                         out_result_lo,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [kuz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                    cfg_data
);
  import kuz_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KS_S, ST_KS_L, ST_KS_F, ST_E_XS, ST_E_L,
    ST_D_X, ST_D_L, ST_D_S, ST_FIN
  } state_t;

  localparam logic [RK_IDX_W-1:0] RK_FIRST = RK_IDX_W'(0);
  localparam logic [RK_IDX_W-1:0] RK_LAST  = RK_IDX_W'(NUM_RKEYS - 1);

  state_t               state_r;
  logic                 keys_ready_r;
  logic                 func_r;
  logic [3:0]           cnt_r;
  logic [RK_IDX_W-1:0]  rnd_r;
  logic [4:0]           kstep_r;
  blk_t                 blk_r;
  blk_t                 in_blk_r;
  blk_t                 a1_r;
  blk_t                 a0_r;
  blk_t                 rk_r [NUM_RKEYS];
  logic [63:0]          key_r [4];
  logic                 out_valid_r;
  blk_t                 res_r;

  blk_t                 ks_new;
  blk_t                 fin_val;
  logic [RK_IDX_W-1:0]  ks_idx;
  logic                 out_free;

  assign in_stall      = (state_r != ST_IDLE);
  assign cfg_ready     = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_result_hi = res_r[127:64];
  assign out_result_lo = res_r[63:0];

  assign ks_new   = blk_r ^ a0_r;
  assign ks_idx   = RK_IDX_W'({kstep_r[4:3], 1'b0}) + RK_IDX_W'(2);
  assign fin_val  = blk_r ^ rk_r[func_r ? RK_FIRST : RK_LAST];
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      key_r[0]     <= '0;
      key_r[1]     <= '0;
      key_r[2]     <= '0;
      key_r[3]     <= '0;
    end else begin
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          KEY_WORD0: begin key_r[0] <= cfg_data; keys_ready_r <= 1'b0; end
          KEY_WORD1: begin key_r[1] <= cfg_data; keys_ready_r <= 1'b0; end
          KEY_WORD2: begin key_r[2] <= cfg_data; keys_ready_r <= 1'b0; end
          KEY_WORD3: begin key_r[3] <= cfg_data; keys_ready_r <= 1'b0; end
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            blk_r    <= {in_block_hi, in_block_lo};
            in_blk_r <= {in_block_hi, in_block_lo};
            func_r   <= in_func;
            cnt_r    <= '0;
            if (!keys_ready_r) begin
              a1_r     <= {key_r[0], key_r[1]};
              a0_r     <= {key_r[2], key_r[3]};
              rk_r[0]  <= {key_r[0], key_r[1]};
              rk_r[1]  <= {key_r[2], key_r[3]};
              kstep_r  <= '0;
              state_r  <= ST_KS_S;
            end else if (in_func) begin
              rnd_r   <= RK_LAST;
              state_r <= ST_D_X;
            end else begin
              rnd_r   <= RK_FIRST;
              state_r <= ST_E_XS;
            end
          end
        end
        // key schedule: one Feistel step = S, 16 R steps, fold
        ST_KS_S: begin
          a1_r    <= a1_r;
          blk_r   <= s_fwd(a1_r ^ KS_CONST[kstep_r]);
          cnt_r   <= '0;
          state_r <= ST_KS_L;
        end
        ST_KS_L: begin
          blk_r <= r_fwd(blk_r);
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= ST_KS_F;
        end
        ST_KS_F: begin
          a1_r    <= ks_new;
          a0_r    <= a1_r;
          kstep_r <= kstep_r + 5'd1;
          if (kstep_r[2:0] == 3'd7) begin
            rk_r[ks_idx]                 <= ks_new;
            rk_r[ks_idx + RK_IDX_W'(1)]  <= a1_r;
          end
          if (kstep_r == 5'd31) begin
            keys_ready_r <= 1'b1;
            // reload the block saved at transfer
            blk_r <= in_blk_r;
            if (func_r) begin
              rnd_r   <= RK_LAST;
              state_r <= ST_D_X;
            end else begin
              rnd_r   <= RK_FIRST;
              state_r <= ST_E_XS;
            end
          end else begin
            state_r <= ST_KS_S;
          end
        end
        ST_E_XS: begin
          blk_r   <= s_fwd(blk_r ^ rk_r[rnd_r]);
          cnt_r   <= '0;
          state_r <= ST_E_L;
        end
        ST_E_L: begin
          blk_r <= r_fwd(blk_r);
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            rnd_r   <= rnd_r + RK_IDX_W'(1);
            state_r <= (rnd_r == RK_IDX_W'(NUM_RKEYS - 2)) ? ST_FIN : ST_E_XS;
          end
        end
        ST_D_X: begin
          blk_r   <= blk_r ^ rk_r[rnd_r];
          cnt_r   <= '0;
          state_r <= ST_D_L;
        end
        ST_D_L: begin
          blk_r <= r_inv(blk_r);
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= ST_D_S;
        end
        ST_D_S: begin
          blk_r   <= s_inv(blk_r);
          rnd_r   <= rnd_r - RK_IDX_W'(1);
          state_r <= (rnd_r == RK_IDX_W'(1)) ? ST_FIN : ST_D_X;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            res_r       <= fin_val;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
